// File: design/cht_pkg.sv
// Shared types and constants for the contact history table.
// Used by cht_store, cht_ctrl and contact_history_table; depends on nothing.
package cht_pkg;

  localparam int NID_W  = 24;
  localparam int KIND_W = 8;
  localparam int BODY_W = 16;
  localparam int ELG_W  = 64;

  localparam logic [KIND_W-1:0] BODY_MATCH_KIND = 8'd10;

  typedef enum logic [1:0] {
    FN_LOOKUP = 2'd0,
    FN_ADD    = 2'd1,
    FN_SWAP   = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef struct packed {
    logic [NID_W-1:0]  nid;
    logic [KIND_W-1:0] kind;
    logic [BODY_W-1:0] body;
    logic [ELG_W-1:0]  ex;
    logic [ELG_W-1:0]  ey;
    logic [ELG_W-1:0]  ez;
  } entry_t;

  typedef struct packed {
    logic              hit;
    logic              status;
    logic [ELG_W-1:0]  fx;
    logic [ELG_W-1:0]  fy;
    logic [ELG_W-1:0]  fz;
  } res_t;

endpackage

// File: design/contact_history_table.sv
// Lookup: the scan reads one stored entry per cycle from one port, stopping at the first
// hit or after the last live entry; add, swap and no-op skip the scan. A new request is
// taken once the previous result has moved into the output register. Synchronous
// active-low reset empties both banks and selects bank 0 as live; entry contents stay
// undefined until written.
module contact_history_table #(
  parameter int MAX_CONTACTS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_func,
  input  logic [cht_pkg::NID_W-1:0]  in_neighbour_id,
  input  logic [cht_pkg::KIND_W-1:0] in_contact_type,
  input  logic [cht_pkg::BODY_W-1:0] in_body_number,
  input  logic [cht_pkg::ELG_W-1:0]  in_elong_x,
  input  logic [cht_pkg::ELG_W-1:0]  in_elong_y,
  input  logic [cht_pkg::ELG_W-1:0]  in_elong_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_hit,
  output logic                      out_status,
  output logic [cht_pkg::ELG_W-1:0]  out_found_x,
  output logic [cht_pkg::ELG_W-1:0]  out_found_y,
  output logic [cht_pkg::ELG_W-1:0]  out_found_z
);
  import cht_pkg::*;

  localparam int IDX_W = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
  localparam int CNT_W = $clog2(MAX_CONTACTS + 1);

  logic             wr_en;
  logic [IDX_W:0]   wr_addr;
  logic [IDX_W:0]   rd_addr;
  entry_t           wr_data;
  entry_t           rd_data;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             out_valid_r;
  res_t             out_r;

  cht_store #(
    .AW (IDX_W + 1)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cht_ctrl #(
    .MAX_CONTACTS (MAX_CONTACTS),
    .IDX_W        (IDX_W),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_neighbour_id (in_neighbour_id),
    .in_contact_type (in_contact_type),
    .in_body_number  (in_body_number),
    .in_elong_x      (in_elong_x),
    .in_elong_y      (in_elong_y),
    .in_elong_z      (in_elong_z),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_r.hit;
  assign out_status  = out_r.status;
  assign out_found_x = out_r.fx;
  assign out_found_y = out_r.fy;
  assign out_found_z = out_r.fz;

endmodule

// File: design/cht_store.sv
// Entry memory for both banks: one write port, one read port, registered read data.
// Depends on cht_pkg for the entry layout.
module cht_store #(
  parameter int AW = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  cht_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output cht_pkg::entry_t rd_data
);
  import cht_pkg::*;

  entry_t mem [2**AW];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/cht_ctrl.sv
// Request sequencer: bank bookkeeping, add and swap handling, and the lookup scan
// that steps one stored entry per cycle through a single compare unit. Uses cht_pkg.
module cht_ctrl #(
  parameter int MAX_CONTACTS = 32,
  parameter int IDX_W        = 5,
  parameter int CNT_W        = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_func,
  input  logic [cht_pkg::NID_W-1:0]  in_neighbour_id,
  input  logic [cht_pkg::KIND_W-1:0] in_contact_type,
  input  logic [cht_pkg::BODY_W-1:0] in_body_number,
  input  logic [cht_pkg::ELG_W-1:0]  in_elong_x,
  input  logic [cht_pkg::ELG_W-1:0]  in_elong_y,
  input  logic [cht_pkg::ELG_W-1:0]  in_elong_z,
  output logic                      wr_en,
  output logic [IDX_W:0]            wr_addr,
  output cht_pkg::entry_t           wr_data,
  output logic [IDX_W:0]            rd_addr,
  input  cht_pkg::entry_t           rd_data,
  output logic                      res_valid,
  input  logic                      res_ready,
  output cht_pkg::res_t             res
);
  import cht_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

  state_t            state_r, state_nxt;
  logic              live_bank_r, live_bank_nxt;
  logic [CNT_W-1:0]  live_cnt_r, live_cnt_nxt;
  logic [CNT_W-1:0]  build_cnt_r, build_cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  res_t              res_r, res_nxt;
  logic [NID_W-1:0]  nid_r;
  logic [KIND_W-1:0] kind_r;
  logic [BODY_W-1:0] body_r;
  logic              in_fire;
  logic              match;
  logic [IDX_W-1:0]  idx_inc;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign res_valid = (state_r == ST_RESP);
  assign res       = res_r;
  assign idx_inc   = idx_r + IDX_W'(1);

  assign wr_addr = {~live_bank_r, build_cnt_r[IDX_W-1:0]};
  assign wr_data = '{nid: in_neighbour_id, kind: in_contact_type, body: in_body_number,
                     ex: in_elong_x, ey: in_elong_y, ez: in_elong_z};

  assign match = (rd_data.nid == nid_r) && (rd_data.kind == kind_r) &&
                 ((kind_r != BODY_MATCH_KIND) || (rd_data.body == body_r));

  always_comb begin
    state_nxt     = state_r;
    live_bank_nxt = live_bank_r;
    live_cnt_nxt  = live_cnt_r;
    build_cnt_nxt = build_cnt_r;
    idx_nxt       = idx_r;
    res_nxt       = res_r;
    wr_en         = 1'b0;
    rd_addr       = {live_bank_r, idx_inc};
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_nxt   = '0;
          state_nxt = ST_RESP;
          unique case (func_t'(in_func))
            FN_LOOKUP: begin
              idx_nxt = '0;
              rd_addr = {live_bank_r, {IDX_W{1'b0}}};
              if (live_cnt_r != '0) begin
                state_nxt = ST_SCAN;
              end
            end
            FN_ADD: begin
              if (build_cnt_r == CNT_W'(MAX_CONTACTS)) begin
                res_nxt.status = 1'b1;
              end else begin
                wr_en         = 1'b1;
                build_cnt_nxt = build_cnt_r + CNT_W'(1);
              end
            end
            FN_SWAP: begin
              live_bank_nxt = ~live_bank_r;
              live_cnt_nxt  = build_cnt_r;
              build_cnt_nxt = '0;
            end
            FN_NOP: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (match) begin
          res_nxt   = '{hit: 1'b1, status: 1'b0, fx: rd_data.ex, fy: rd_data.ey,
                        fz: rd_data.ez};
          state_nxt = ST_RESP;
        end else if (CNT_W'(idx_r) + CNT_W'(1) == live_cnt_r) begin
          res_nxt   = '0;
          state_nxt = ST_RESP;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      ST_RESP: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      live_bank_r <= 1'b0;
      live_cnt_r  <= '0;
      build_cnt_r <= '0;
      idx_r       <= '0;
      res_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      live_bank_r <= live_bank_nxt;
      live_cnt_r  <= live_cnt_nxt;
      build_cnt_r <= build_cnt_nxt;
      idx_r       <= idx_nxt;
      res_r       <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      nid_r  <= in_neighbour_id;
      kind_r <= in_contact_type;
      body_r <= in_body_number;
    end
  end

endmodule

// File: design/cht_checker.sv
// Port-level checks for contact_history_table, bound to every instance of it.
// Sees only the top-level ports; no package dependency.
module cht_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic        out_status,
  input logic [63:0] out_found_x,
  input logic [63:0] out_found_y,
  input logic [63:0] out_found_z
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_status) &&
      $stable(out_found_x) && $stable(out_found_y) && $stable(out_found_z))
    else $error("stalled result changed");

  a_hit_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_status))
    else $error("hit and dropped add in one result");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_found_x == 64'd0 && out_found_y == 64'd0 &&
      out_found_z == 64'd0)
    else $error("nonzero elongation without hit");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in progress");

endmodule

bind contact_history_table cht_checker u_cht_checker (.*);
